### sv/qdc_pkg.sv
// shared types and constants for the quadrature dial counter
`default_nettype none

package qdc_pkg;

  localparam int unsigned DialW  = 15;
  localparam int unsigned DeltaW = 8;
  localparam int unsigned StepW  = 8;
  localparam int unsigned SpcW   = 9;
  localparam int unsigned NvW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  localparam logic [DialW-1:0] DialMaxLimit = 15'd32767;

  typedef enum logic [2:0] {
    OP_EDGE_A  = 3'd0,
    OP_EDGE_B  = 3'd1,
    OP_REFRESH = 3'd2,
    OP_SET     = 3'd3,
    OP_INIT    = 3'd4
  } qdc_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STEPS_PER_COUNT = 2'd0,
    CFG_MAX_VALUE       = 2'd1,
    CFG_WRAP_MODE       = 2'd2
  } qdc_cfg_idx_e;

  typedef struct packed {
    logic [2:0]     op;
    logic           level_a;
    logic           level_b;
    logic [NvW-1:0] new_value;
  } qdc_item_t;

  typedef struct packed {
    logic [SpcW-1:0]  steps_per_count;
    logic [DialW-1:0] max_value;
    logic             wrap_mode;
  } qdc_cfg_t;

  typedef struct packed {
    logic [DialW-1:0]  dial;
    logic [DeltaW-1:0] applied_delta;
    logic              ccw;
  } qdc_result_t;

endpackage

`default_nettype wire

### sv/qdc_in_stage.sv
// input register stage holding one accepted request
`default_nettype none

module qdc_in_stage (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  qdc_pkg::qdc_item_t item_i,
  input  wire               take_i,
  output logic              valid_o,
  output qdc_pkg::qdc_item_t item_o
);

  logic               valid_q, valid_d;
  qdc_pkg::qdc_item_t item_q;
  logic               load;

  assign in_stall_o = valid_q & ~take_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### sv/qdc_core.sv
// decoder state and single-pass update for one request
`default_nettype none

module qdc_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 take_i,
  input  qdc_pkg::qdc_item_t  item_i,
  input  qdc_pkg::qdc_cfg_t   cfg_i,
  input  wire                 clr_steps_i,
  output qdc_pkg::qdc_result_t result_o
);

  logic chan_a_q, chan_a_d, chan_b_q, chan_b_d;
  logic expect_a_q, expect_a_d, expect_b_q, expect_b_d;
  logic reverse_a_q, reverse_a_d, reverse_b_q, reverse_b_d;
  logic ccw_q, ccw_d;
  logic [qdc_pkg::StepW-1:0]  step_count_q, step_count_d;
  logic [qdc_pkg::DeltaW-1:0] pending_q, pending_d;
  logic [qdc_pkg::DeltaW-1:0] applied_q, applied_d;
  logic [qdc_pkg::DialW-1:0]  dial_q, dial_d;

  logic [qdc_pkg::StepW-1:0] threshold;
  logic                      do_refresh;
  logic [qdc_pkg::NvW:0]     base;
  logic [qdc_pkg::NvW+1:0]   sum;
  logic                      sum_neg, sum_over;

  assign threshold = cfg_i.steps_per_count[qdc_pkg::StepW-1:0] - 8'd1;

  // refresh arithmetic, shared by refresh and set value
  always_comb begin
    do_refresh = 1'b0;
    base       = {2'b00, dial_q};
    case (item_i.op)
      qdc_pkg::OP_REFRESH: begin
        do_refresh = 1'b1;
      end
      qdc_pkg::OP_SET: begin
        do_refresh = 1'b1;
        base       = {item_i.new_value[qdc_pkg::NvW-1], item_i.new_value};
      end
      default: begin
        do_refresh = 1'b0;
      end
    endcase
    sum      = {base[qdc_pkg::NvW], base}
             + {{(qdc_pkg::NvW+2-qdc_pkg::DeltaW){pending_q[qdc_pkg::DeltaW-1]}}, pending_q};
    sum_neg  = sum[qdc_pkg::NvW+1];
    sum_over = ~sum_neg && (sum[qdc_pkg::NvW:0] > {2'b00, cfg_i.max_value});
  end

  always_comb begin
    chan_a_d     = chan_a_q;
    chan_b_d     = chan_b_q;
    expect_a_d   = expect_a_q;
    expect_b_d   = expect_b_q;
    reverse_a_d  = reverse_a_q;
    reverse_b_d  = reverse_b_q;
    ccw_d        = ccw_q;
    step_count_d = step_count_q;
    pending_d    = pending_q;
    applied_d    = applied_q;
    dial_d       = dial_q;

    case (item_i.op)
      qdc_pkg::OP_EDGE_A, qdc_pkg::OP_EDGE_B: begin
        if (item_i.op == qdc_pkg::OP_EDGE_A) begin
          chan_a_d = item_i.level_a;
        end else begin
          chan_b_d = item_i.level_b;
        end
        if (chan_a_d == expect_a_q && chan_b_d == expect_b_q) begin
          // forward step: prescaler, then saturating delta
          if (step_count_q == threshold) begin
            step_count_d = '0;
            if (ccw_q) begin
              if (pending_q != 8'h80) pending_d = pending_q - 8'd1;
            end else begin
              if (pending_q != 8'h7f) pending_d = pending_q + 8'd1;
            end
          end else begin
            step_count_d = step_count_q + 8'd1;
          end
          expect_a_d  = (chan_b_d == ccw_q);
          expect_b_d  = (chan_a_d != ccw_q);
          reverse_a_d = ~chan_a_d;
          reverse_b_d = ~chan_b_d;
        end else if (chan_a_d == reverse_a_q && chan_b_d == reverse_b_q) begin
          ccw_d        = ~ccw_q;
          expect_a_d   = (chan_b_d == ccw_d);
          expect_b_d   = (chan_a_d != ccw_d);
          reverse_a_d  = ~chan_a_d;
          reverse_b_d  = ~chan_b_d;
          step_count_d = '0;
        end
      end
      qdc_pkg::OP_INIT: begin
        // patterns armed with the direction held before the init
        chan_a_d    = item_i.level_a;
        chan_b_d    = item_i.level_b;
        expect_a_d  = (item_i.level_b == ccw_q);
        expect_b_d  = (item_i.level_a != ccw_q);
        reverse_a_d = ~item_i.level_a;
        reverse_b_d = ~item_i.level_b;
        ccw_d       = 1'b0;
      end
      default: begin
      end
    endcase

    if (do_refresh) begin
      applied_d = pending_q;
      pending_d = '0;
      if (sum_neg) begin
        dial_d = cfg_i.wrap_mode ? cfg_i.max_value : '0;
      end else if (sum_over) begin
        dial_d = cfg_i.wrap_mode ? '0 : cfg_i.max_value;
      end else begin
        dial_d = sum[qdc_pkg::DialW-1:0] & qdc_pkg::DialMaxLimit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_a_q     <= 1'b1;
      chan_b_q     <= 1'b1;
      expect_a_q   <= 1'b1;
      expect_b_q   <= 1'b0;
      reverse_a_q  <= 1'b0;
      reverse_b_q  <= 1'b0;
      ccw_q        <= 1'b0;
      step_count_q <= '0;
      pending_q    <= '0;
      applied_q    <= '0;
      dial_q       <= '0;
    end else begin
      if (take_i) begin
        chan_a_q    <= chan_a_d;
        chan_b_q    <= chan_b_d;
        expect_a_q  <= expect_a_d;
        expect_b_q  <= expect_b_d;
        reverse_a_q <= reverse_a_d;
        reverse_b_q <= reverse_b_d;
        ccw_q       <= ccw_d;
        pending_q   <= pending_d;
        applied_q   <= applied_d;
        dial_q      <= dial_d;
      end
      if (clr_steps_i) begin
        step_count_q <= '0;
      end else if (take_i) begin
        step_count_q <= step_count_d;
      end
    end
  end

  assign result_o.dial          = dial_d;
  assign result_o.applied_delta = applied_d;
  assign result_o.ccw           = ccw_d;

endmodule

`default_nettype wire

### sv/quadrature_dial_counter.sv
// top level: quadrature dial counter with config registers and result register
//
//   channel   signals                                     dir   moves
//   in        in_valid_i / in_stall_o, op..new_value      in    one request
//   out       out_valid_o / out_stall_i, dial..direction  out   one result per request
//   cfg       cfg_we_i, cfg_index_i, cfg_data_i           in    one register write
//
// one request per cycle sustained while out_stall_i is low; a request passes the input
// register, then the single-pass update into the result register, which drives out_valid_o
// the decoder state updates in the same cycle the request moves into the result register
// a stalled result holds the result register; one more request waits in the input register
// and in_stall_o rises only when both are full
// reset clears all state and restores steps_per_count=1, max_value=32767, wrap_mode=0
`default_nettype none

module quadrature_dial_counter (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  op_i,
  input  wire         level_a_i,
  input  wire         level_b_i,
  input  wire  signed [15:0] new_value_i,
  // result channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [14:0] dial_value_o,
  output logic signed [7:0] last_delta_o,
  output logic        direction_ccw_o,
  // config write port
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [qdc_pkg::CfgDataW-1:0] cfg_data_i
);

  qdc_pkg::qdc_item_t   in_item;
  qdc_pkg::qdc_item_t   stage_item;
  logic                 stage_valid;
  logic                 take;
  qdc_pkg::qdc_cfg_t    cfg_q;
  logic                 clr_steps;
  qdc_pkg::qdc_result_t result_next;
  qdc_pkg::qdc_result_t result_q;
  logic                 out_valid_q, out_valid_d;

  assign in_item.op        = op_i;
  assign in_item.level_a   = level_a_i;
  assign in_item.level_b   = level_b_i;
  assign in_item.new_value = new_value_i;

  // the held request moves on whenever the result register is free or being drained
  assign take = stage_valid & (~out_valid_q | ~out_stall_i);

  qdc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  // config registers; a steps_per_count write also clears the prescaler
  assign clr_steps = cfg_we_i && (cfg_index_i == qdc_pkg::CFG_STEPS_PER_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_count <= 9'd1;
      cfg_q.max_value       <= qdc_pkg::DialMaxLimit;
      cfg_q.wrap_mode       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        qdc_pkg::CFG_STEPS_PER_COUNT: begin
          cfg_q.steps_per_count <= cfg_data_i[qdc_pkg::SpcW-1:0];
        end
        qdc_pkg::CFG_MAX_VALUE: begin
          cfg_q.max_value <= cfg_data_i;
        end
        qdc_pkg::CFG_WRAP_MODE: begin
          cfg_q.wrap_mode <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  qdc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (stage_item),
    .cfg_i       (cfg_q),
    .clr_steps_i (clr_steps),
    .result_o    (result_next)
  );

  // result register
  assign out_valid_d = take | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= result_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dial_value_o    = result_q.dial;
  assign last_delta_o    = result_q.applied_delta;
  assign direction_ccw_o = result_q.ccw;

  // a request stalls at the input only while one is already held
  a_stall_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> stage_valid)
    else $error("input stalled with no request held");

  // a request moving on always lands in the result register
  a_take_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_valid_q)
    else $error("result register empty after a request moved on");

  // a refresh or set value leaves the dial within range
  a_refresh_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !cfg_we_i &&
     (stage_item.op == qdc_pkg::OP_REFRESH || stage_item.op == qdc_pkg::OP_SET))
    |=> (result_q.dial <= cfg_q.max_value))
    else $error("dial above max_value after refresh");

endmodule

`default_nettype wire

### sim/quadrature_dial_counter_test.sv
// self-checking testbench for the quadrature dial counter: directed and random requests
`timescale 1ns / 1ps

module quadrature_dial_counter_test;

  // op codes that the block leaves unused
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // clock, reset and block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  op_i = qdc_pkg::OP_REFRESH;
  logic        level_a_i = 1'b0;
  logic        level_b_i = 1'b0;
  logic signed [15:0] new_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [14:0] dial_value_o;
  logic signed [7:0] last_delta_o;
  logic        direction_ccw_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = qdc_pkg::CFG_STEPS_PER_COUNT;
  logic [14:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  quadrature_dial_counter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .level_a_i      (level_a_i),
    .level_b_i      (level_b_i),
    .new_value_i    (new_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dial_value_o   (dial_value_o),
    .last_delta_o   (last_delta_o),
    .direction_ccw_o(direction_ccw_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // decoder state as the block should hold it, reset values as initializers
  logic [8:0]  cfg_spc  = 9'd1;
  logic [14:0] cfg_max  = qdc_pkg::DialMaxLimit;
  logic        cfg_wrap = 1'b0;
  logic        pin_a = 1'b1;
  logic        pin_b = 1'b1;
  logic        want_a = 1'b1;
  logic        want_b = 1'b0;
  logic        back_a = 1'b0;
  logic        back_b = 1'b0;
  logic        turning_ccw = 1'b0;
  logic [7:0]  step_tally = '0;
  int          pend_delta = 0;
  int          last_applied = 0;
  logic [14:0] dial_pos = '0;

  // readings still owed by the block, oldest first
  qdc_pkg::qdc_result_t readings_due[$];
  qdc_pkg::qdc_result_t due_reading;
  qdc_pkg::qdc_result_t seen_reading;
  int          fail_count = 0;

  // idling knobs, percent per cycle
  int send_idle_pct = 0;
  int stall_pct = 0;

  // long receiver hold-off, counted in its own process
  event hold_start;
  int   hold_cycles = 0;
  logic hold_off = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // next-step pattern follows the held direction, reverse pattern flips both pins
  function automatic void rearm_patterns();
    want_a = (pin_b == turning_ccw);
    want_b = (pin_a != turning_ccw);
    back_a = ~pin_a;
    back_b = ~pin_b;
  endfunction

  // compare the pins with both patterns after a channel edge
  function automatic void track_transition();
    logic [7:0] step_limit;
    // threshold wraps to 255 when steps_per_count has zero low bits
    step_limit = cfg_spc[7:0] - 8'd1;
    if (pin_a == want_a && pin_b == want_b) begin
      if (step_tally == step_limit) begin
        // pending delta saturates at both ends of the signed byte
        if (turning_ccw) begin
          if (pend_delta > -128) pend_delta--;
        end else if (pend_delta < 127) begin
          pend_delta++;
        end
        step_tally = '0;
      end else begin
        step_tally = step_tally + 8'd1;
      end
      rearm_patterns();
    end else if (pin_a == back_a && pin_b == back_b) begin
      turning_ccw = ~turning_ccw;
      rearm_patterns();
      step_tally = '0;
    end
  endfunction

  // move the pending delta into the dial, clamp or wrap against max_value
  function automatic void fold_delta(input int base);
    int total;
    int lim;
    lim = int'(cfg_max);
    last_applied = pend_delta;
    pend_delta = 0;
    total = base + last_applied;
    if (total < 0) begin
      total = cfg_wrap ? lim : 0;
    end else if (total > lim) begin
      total = cfg_wrap ? 0 : lim;
    end
    dial_pos = total[14:0];
  endfunction

  // advance the predicted state by one request and return the reading it gives
  function automatic qdc_pkg::qdc_result_t predict_reading(input logic [2:0] op,
                                                           input logic la,
                                                           input logic lb,
                                                           input logic signed [15:0] nv);
    qdc_pkg::qdc_result_t reading;
    case (op)
      qdc_pkg::OP_EDGE_A: begin
        pin_a = la;
        track_transition();
      end
      qdc_pkg::OP_EDGE_B: begin
        pin_b = lb;
        track_transition();
      end
      qdc_pkg::OP_REFRESH: fold_delta(int'(dial_pos));
      qdc_pkg::OP_SET: fold_delta(int'(nv));
      qdc_pkg::OP_INIT: begin
        // patterns use the old direction, then the direction goes clockwise
        pin_a = la;
        pin_b = lb;
        rearm_patterns();
        turning_ccw = 1'b0;
      end
      default: ;
    endcase
    reading.dial = dial_pos;
    reading.applied_delta = last_applied[7:0];
    reading.ccw = turning_ccw;
    return reading;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_reading = {dial_value_o, last_delta_o, direction_ccw_o};
      if (readings_due.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result dial=%0d delta=%0d ccw=%0b at %0t",
                   dial_value_o, last_delta_o, direction_ccw_o, $realtime);
        fail_count++;
      end else begin
        due_reading = readings_due.pop_front();
        if (seen_reading !== due_reading) begin
          if (fail_count < 10)
            $display({"mismatch at %0t: expected dial=%0d delta=%0d ccw=%0b, ",
                      "got dial=%0d delta=%0d ccw=%0b"},
                     $realtime, due_reading.dial, $signed(due_reading.applied_delta),
                     due_reading.ccw, dial_value_o, last_delta_o, direction_ccw_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always begin
    @(hold_start);
    hold_off <= 1'b1;
    repeat (hold_cycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom);
  endfunction

  // offer one request, hold it until accepted, then predict its reading
  task automatic send_request(input logic [2:0] op, input logic la, input logic lb,
                              input logic signed [15:0] nv);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    level_a_i   <= la;
    level_b_i   <= lb;
    new_value_i <= nv;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    readings_due.push_back(predict_reading(op, la, lb, nv));
  endtask

  // one well-formed detent: exactly one pin differs from the next-step pattern
  task automatic send_step();
    if (pin_a != want_a)
      send_request(qdc_pkg::OP_EDGE_A, want_a, rand_bit(), rand_word());
    else
      send_request(qdc_pkg::OP_EDGE_B, rand_bit(), want_b, rand_word());
  endtask

  // direction change: flip the pin the next step would not touch, then the other
  task automatic send_reversal();
    if (pin_a != want_a) begin
      send_request(qdc_pkg::OP_EDGE_B, rand_bit(), ~pin_b, rand_word());
      send_request(qdc_pkg::OP_EDGE_A, ~pin_a, rand_bit(), rand_word());
    end else begin
      send_request(qdc_pkg::OP_EDGE_A, ~pin_a, rand_bit(), rand_word());
      send_request(qdc_pkg::OP_EDGE_B, rand_bit(), ~pin_b, rand_word());
    end
  endtask

  // mostly clean rotation with refreshes, some set, initialize, noise and spare codes
  task automatic send_random_item();
    int pick;
    logic signed [15:0] nv;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_step();
    end else if (pick < 63) begin
      send_reversal();
    end else if (pick < 77) begin
      send_request(qdc_pkg::OP_REFRESH, rand_bit(), rand_bit(), rand_word());
    end else if (pick < 83) begin
      // set values: anywhere, around max_value, around zero, the signed ends
      case ($urandom_range(3))
        0: nv = rand_word();
        1: nv = 16'(int'(cfg_max) + int'($urandom_range(6)) - 3);
        2: nv = 16'(int'($urandom_range(40)) - 20);
        default: nv = rand_bit() ? 16'sh7fff : 16'sh8000;
      endcase
      send_request(qdc_pkg::OP_SET, rand_bit(), rand_bit(), nv);
    end else if (pick < 87) begin
      send_request(qdc_pkg::OP_INIT, rand_bit(), rand_bit(), rand_word());
    end else if (pick < 97) begin
      // bounce or out-of-order edge
      send_request(rand_bit() ? qdc_pkg::OP_EDGE_B : qdc_pkg::OP_EDGE_A, rand_bit(),
                   rand_bit(), rand_word());
    end else begin
      send_request(3'($urandom_range(OpSpareHi, OpSpareLo)), rand_bit(), rand_bit(),
                   rand_word());
    end
  endtask

  // stop offering and wait for every owed reading, then cover the pipeline depth
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_register(input qdc_pkg::qdc_cfg_idx_e idx, input logic [14:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      qdc_pkg::CFG_STEPS_PER_COUNT: begin
        cfg_spc = value[8:0];
        step_tally = '0;
      end
      qdc_pkg::CFG_MAX_VALUE: cfg_max = value;
      qdc_pkg::CFG_WRAP_MODE: cfg_wrap = value[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // spare codes report the reset state and change nothing
    send_request(OpSpareLo, 1'b1, 1'b1, 16'sh7fff);
    send_request(OpSpareHi, 1'b0, 1'b0, 16'sh8000);
    send_request(qdc_pkg::OP_REFRESH, 1'b0, 1'b1, '0);
    // set value at both ends of the signed range; the negative end clamps to zero
    send_request(qdc_pkg::OP_SET, 1'b1, 1'b0, 16'sh7fff);
    send_request(qdc_pkg::OP_SET, 1'b0, 1'b1, 16'sh8000);
    // clockwise detents, refresh, then turn around
    repeat (2) send_step();
    send_request(qdc_pkg::OP_REFRESH, 1'b1, 1'b1, rand_word());
    send_reversal();
    repeat (2) send_step();
    // initialize keeps the old direction's patterns, then reports clockwise
    send_request(qdc_pkg::OP_INIT, 1'b0, 1'b1, rand_word());
    send_request(qdc_pkg::OP_REFRESH, 1'b0, 1'b0, rand_word());
    send_request(qdc_pkg::OP_SET, 1'b1, 1'b1, -16'sd1);
    // wrapping: below zero lands on max, above max lands on zero
    wait_for_drain();
    write_register(qdc_pkg::CFG_WRAP_MODE, 15'd1);
    send_request(qdc_pkg::OP_SET, 1'b0, 1'b0, -16'sd5);
    send_step();
    send_request(qdc_pkg::OP_SET, 1'b1, 1'b0, 16'sh7fff);
    send_request(qdc_pkg::OP_SET, 1'b0, 1'b1, 16'sd30000);
    // shrinking the range leaves the dial above max until the next refresh
    wait_for_drain();
    write_register(qdc_pkg::CFG_MAX_VALUE, 15'd100);
    write_register(qdc_pkg::CFG_WRAP_MODE, 15'd0);
    send_request(OpSpareHi, 1'b1, 1'b1, rand_word());
    send_request(qdc_pkg::OP_REFRESH, 1'b1, 1'b0, rand_word());
    // zero steps_per_count means one count per 256 steps
    wait_for_drain();
    write_register(qdc_pkg::CFG_STEPS_PER_COUNT, 15'd0);
    repeat (2) send_step();
    send_request(qdc_pkg::OP_INIT, 1'b1, 1'b0, rand_word());
  endtask

  task automatic test_delta_saturation();
    wait_for_drain();
    write_register(qdc_pkg::CFG_STEPS_PER_COUNT, 15'd1);
    write_register(qdc_pkg::CFG_MAX_VALUE, qdc_pkg::DialMaxLimit);
    write_register(qdc_pkg::CFG_WRAP_MODE, 15'd0);
    send_request(qdc_pkg::OP_SET, 1'b0, 1'b0, 16'sd200);
    // clockwise past +127, then counter-clockwise past -128
    repeat (135) send_step();
    send_request(qdc_pkg::OP_REFRESH, 1'b0, 1'b0, rand_word());
    send_reversal();
    repeat (135) send_step();
    send_request(qdc_pkg::OP_REFRESH, 1'b1, 1'b1, rand_word());
  endtask

  task automatic test_config_sweep();
    int spc_set [8]   = '{1, 256, 0, 2, 511, 3, 1, 4};
    int max_set [8]   = '{32767, 100, 0, 1, 20, 32767, 5, 300};
    int wrap_set [8]  = '{0, 1, 0, 1, 1, 0, 1, 0};
    int idle_set [4]  = '{0, 53, 0, 25};
    int stall_set [4] = '{0, 0, 53, 25};
    for (int ph = 0; ph < 8; ph++) begin
      wait_for_drain();
      write_register(qdc_pkg::CFG_STEPS_PER_COUNT, 15'(spc_set[ph]));
      write_register(qdc_pkg::CFG_MAX_VALUE, 15'(max_set[ph]));
      write_register(qdc_pkg::CFG_WRAP_MODE, 15'(wrap_set[ph]));
      // idling pattern rotates: none, sender gaps, receiver stalls, both
      send_idle_pct = idle_set[ph % 4];
      stall_pct = stall_set[ph % 4];
      repeat (175) send_random_item();
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    wait_for_drain();
    send_idle_pct = 0;
    stall_pct = 0;
    // receiver holds off while requests keep coming, block must stall its input
    hold_cycles = 48;
    -> hold_start;
    repeat (12) send_random_item();
    // sender pauses until every owed reading is back
    wait_for_drain();
    repeat (12) send_random_item();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_delta_saturation();
    test_config_sweep();
    test_backpressure();
    wait_for_drain();
    if (fail_count == 0 && readings_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
